// ----- rtl/core/ptc_pkg.sv -----
// shared constants, types and helpers for the pitch transition counter
package ptc_pkg;

	localparam int PITCHES    = 128;
	localparam int COUNT_BITS = 16;
	localparam int MAX_TOP    = 64;

	localparam int PBITS     = (PITCHES > 2) ? $clog2(PITCHES) : 1;
	localparam int IDX_BITS  = $clog2(PITCHES * PITCHES);
	localparam int RANK_BITS = $clog2(MAX_TOP + 1);

	localparam int PITCH_W = 7;
	localparam int TOPN_W  = 7;
	localparam int HIT_W   = 16;
	localparam int TOTAL_W = 32;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_NOTE   = 2'd1;
	localparam logic [1:0] OP_REPORT = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;

	typedef struct packed {
		logic [1:0]         op;
		logic [PITCH_W-1:0] pitch;
		logic               song_start;
		logic [TOPN_W-1:0]  top_n;
	} item_t;

	typedef struct packed {
		logic [PITCH_W-1:0] from_pitch;
		logic [PITCH_W-1:0] to_pitch;
		logic [HIT_W-1:0]   hit_count;
		logic [TOTAL_W-1:0] total_count;
		logic               found;
		logic               last;
	} result_t;

	function automatic logic [IDX_BITS-1:0] pair_addr(input logic [PBITS-1:0] r,
		input logic [PBITS-1:0] c);
		return IDX_BITS'(r) * IDX_BITS'(PITCHES) + IDX_BITS'(c);
	endfunction

endpackage

// ----- rtl/core/pitch_transition_counter_top_n.sv -----
// top level of the pitch transition counter with top-n report
//
// channel  dir  fields (lowest bit first)
// s_*      in   tdata: pitch[6:0] song_start[7] top_n[14:8]; tuser: op[1:0]
// m_*      out  tdata: from_pitch to_pitch hit_count total_count; tuser: found; tlast: last
//
// note: a counted transition is read in idle and written back in nwr, else it stays idle;
// clear: 1 beat then a pass of PITCHES*PITCHES zero writes through the table write port
// report: per beat a full scan of PITCHES*PITCHES reads then drain and fin; top_n zero skips it
// after reset the same clearing pass runs with s_tready low
// a stalled output beat holds the report sequencer until it is taken
module pitch_transition_counter_top_n (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // pitch, song_start, top_n, zero pad
	input  logic [1:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // from_pitch, to_pitch, hit_count, total_count, zero pad
	output logic        m_tuser,  // found
	output logic        m_tlast
);

	ptc_pkg::item_t                 item;
	ptc_pkg::result_t               res;
	logic                           rd_en, wr_en;
	logic [ptc_pkg::IDX_BITS-1:0]   rd_addr, wr_addr;
	logic [ptc_pkg::COUNT_BITS-1:0] rd_data, wr_data;
	logic                           out_free, out_load;

	assign item.op         = s_tuser;
	assign item.pitch      = s_tdata[6:0];
	assign item.song_start = s_tdata[7];
	assign item.top_n      = s_tdata[14:8];

	ptc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.item     (item),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.out_free (out_free),
		.out_load (out_load),
		.out_res  (res)
	);

	ptc_table u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	ptc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- rtl/core/ptc_table.sv -----
// pair count memory, one write port and one registered read port
module ptc_table (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [ptc_pkg::IDX_BITS-1:0]   rd_addr,
	output logic [ptc_pkg::COUNT_BITS-1:0] rd_data,
	input  logic                           wr_en,
	input  logic [ptc_pkg::IDX_BITS-1:0]   wr_addr,
	input  logic [ptc_pkg::COUNT_BITS-1:0] wr_data
);

	logic [ptc_pkg::COUNT_BITS-1:0] mem [ptc_pkg::PITCHES * ptc_pkg::PITCHES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/ptc_out.sv -----
// output beat register for report results
module ptc_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ptc_pkg::result_t res,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	logic             valid_q;
	ptc_pkg::result_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q.total_count, res_q.hit_count, res_q.to_pitch,
		res_q.from_pitch};
	assign m_tuser  = res_q.found;
	assign m_tlast  = res_q.last;

endmodule

// ----- rtl/core/ptc_ctrl.sv -----
// sequencer: clearing pass, note read-modify-write and report table scans
module ptc_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  ptc_pkg::item_t                 item,
	output logic                           rd_en,
	output logic [ptc_pkg::IDX_BITS-1:0]   rd_addr,
	input  logic [ptc_pkg::COUNT_BITS-1:0] rd_data,
	output logic                           wr_en,
	output logic [ptc_pkg::IDX_BITS-1:0]   wr_addr,
	output logic [ptc_pkg::COUNT_BITS-1:0] wr_data,
	input  logic                           out_free,
	output logic                           out_load,
	output ptc_pkg::result_t               out_res
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_NWR   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	localparam logic [ptc_pkg::PBITS-1:0] LAST_P = ptc_pkg::PBITS'(ptc_pkg::PITCHES - 1);

	logic [2:0]                      state_q;
	logic [ptc_pkg::PBITS-1:0]       row_q, col_q;
	logic [ptc_pkg::PBITS-1:0]       prev_q;
	logic                            prev_valid_q;
	logic [ptc_pkg::TOTAL_W-1:0]     total_q;
	logic [ptc_pkg::IDX_BITS-1:0]    addr_q;
	logic [ptc_pkg::RANK_BITS-1:0]   rank_q, limit_q;
	logic [ptc_pkg::COUNT_BITS-1:0]  best_q;
	logic [ptc_pkg::PBITS-1:0]       best_row_q, best_col_q;
	logic [1:0]                      nz_q;
	logic                            rd_s1;
	logic [ptc_pkg::PBITS-1:0]       row_s1, col_s1;

	logic                            accept;
	logic                            at_end;
	logic                            in_range;
	logic                            count_it;
	logic [ptc_pkg::RANK_BITS-1:0]   limit_in;
	logic [ptc_pkg::RANK_BITS-1:0]   rank_next;
	logic                            fin_go;
	logic                            last_res;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign at_end    = (row_q == LAST_P) && (col_q == LAST_P);
	assign in_range  = {2'b00, item.pitch} < 9'(ptc_pkg::PITCHES);
	assign count_it  = prev_valid_q && !item.song_start;
	assign limit_in  = (item.top_n > ptc_pkg::TOPN_W'(ptc_pkg::MAX_TOP)) ?
		ptc_pkg::RANK_BITS'(ptc_pkg::MAX_TOP) : ptc_pkg::RANK_BITS'(item.top_n);
	assign rank_next = rank_q + 1'b1;
	assign fin_go    = (state_q == ST_FIN) && out_free;
	assign last_res  = (best_q == '0) || (rank_next == limit_q) || (nz_q < 2'd2);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptc_pkg::pair_addr(row_q, col_q);
		wr_en   = 1'b0;
		wr_addr = ptc_pkg::pair_addr(row_q, col_q);
		wr_data = '0;
		unique case (state_q)
			ST_CLR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				rd_en   = accept && (item.op == ptc_pkg::OP_NOTE) && in_range && count_it;
				rd_addr = ptc_pkg::pair_addr(prev_q, ptc_pkg::PBITS'(item.pitch));
			end
			ST_NWR: begin
				wr_en   = 1'b1;
				wr_addr = addr_q;
				wr_data = (rd_data == ptc_pkg::COUNT_MAX) ? rd_data : rd_data + 1'b1;
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_FIN: begin
				wr_en   = fin_go && (best_q != '0);
				wr_addr = ptc_pkg::pair_addr(best_row_q, best_col_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		out_load            = fin_go;
		out_res.from_pitch  = (best_q == '0) ? '0 : ptc_pkg::PITCH_W'(best_row_q);
		out_res.to_pitch    = (best_q == '0) ? '0 : ptc_pkg::PITCH_W'(best_col_q);
		out_res.hit_count   = ptc_pkg::HIT_W'(best_q);
		out_res.total_count = total_q;
		out_res.found       = (best_q != '0);
		out_res.last        = last_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			row_q        <= '0;
			col_q        <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			total_q      <= '0;
			rank_q       <= '0;
			limit_q      <= '0;
			rd_s1        <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_CLR: begin
					if (at_end) begin
						state_q <= ST_IDLE;
					end
					if (col_q == LAST_P) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					if (accept) begin
						unique case (item.op)
							ptc_pkg::OP_CLEAR: begin
								total_q <= '0;
								state_q <= ST_CLR;
							end
							ptc_pkg::OP_NOTE: begin
								if (in_range) begin
									prev_q       <= ptc_pkg::PBITS'(item.pitch);
									prev_valid_q <= 1'b1;
									if (count_it) begin
										state_q <= ST_NWR;
									end
								end
							end
							ptc_pkg::OP_REPORT: begin
								rank_q  <= '0;
								limit_q <= limit_in;
								state_q <= (limit_in == '0) ? ST_FIN : ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_NWR: begin
					if (total_q != ptc_pkg::TOTAL_MAX) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (at_end) begin
						state_q <= ST_DRAIN;
					end
					if (col_q == LAST_P) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					row_q <= '0;
					col_q <= '0;
					if (fin_go) begin
						rank_q  <= rank_next;
						state_q <= last_res ? ST_IDLE : ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// note address and scan best tracking
	always_ff @(posedge clk) begin
		row_s1 <= row_q;
		col_s1 <= col_q;
		if (rd_en && state_q == ST_IDLE) begin
			addr_q <= rd_addr;
		end
		if ((accept && item.op == ptc_pkg::OP_REPORT) || fin_go) begin
			best_q <= '0;
			nz_q   <= '0;
		end else if (rd_s1) begin
			if (rd_data != '0 && nz_q != 2'd2) begin
				nz_q <= nz_q + 1'b1;
			end
			if (rd_data > best_q) begin
				best_q     <= rd_data;
				best_row_q <= row_s1;
				best_col_q <= col_s1;
			end
		end
	end

endmodule

// ----- rtl/core/ptc_checker.sv -----
// port-level checks for the pitch transition counter, bound to the top level
module ptc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output beat changed while stalled");

	// empty report is a single last beat with zero pair fields
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata[29:0] == 30'd0))
		else $error("malformed empty report beat");

	// a reported transition has a nonzero count
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[29:14] != 16'd0))
		else $error("reported transition with zero count");

	// report and clear keep the input side busy afterwards
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ptc_pkg::OP_REPORT || s_tuser == ptc_pkg::OP_CLEAR)
			|=> !s_tready)
		else $error("input accepted during report or clear");

endmodule

bind pitch_transition_counter_top_n ptc_checker u_ptc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- test/pitch_transition_counter_top_n_tb.sv -----
// testbench for the pitch transition counter with top-n report
module pitch_transition_counter_top_n_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SCAN_CYCLES = ptc_pkg::PITCHES * ptc_pkg::PITCHES + 3;
	localparam int QUIET_LIMIT = 200000;
	localparam int HOLD_CYCLES = 40000;
	localparam int RUN_REPEATS = 8;
	localparam int RANDOM_ITEMS = 140;
	localparam int RANDOM_BEATS = 24;

	class transition_scoreboard;
		bit [ptc_pkg::COUNT_BITS-1:0] pair_hits [ptc_pkg::PITCHES*ptc_pkg::PITCHES];
		bit [ptc_pkg::TOTAL_W-1:0] total;
		bit [ptc_pkg::PITCH_W-1:0] prev_pitch;
		bit prev_ok;
		ptc_pkg::result_t pending_beats [$];
		int errors;
		int beats_predicted;
		int beats_checked;
		int op_seen [4];

		function new();
			wipe_table();
			prev_pitch = '0;
			prev_ok = 1'b0;
		endfunction

		function void wipe_table();
			foreach (pair_hits[i])
				pair_hits[i] = '0;
			total = '0;
		endfunction

		function void take_item(ptc_pkg::item_t it);
			int idx;
			int best_idx;
			int limit;
			bit [ptc_pkg::COUNT_BITS-1:0] best;
			bit have_held;
			ptc_pkg::result_t held;
			op_seen[it.op]++;
			case (it.op)
				ptc_pkg::OP_CLEAR: begin
					wipe_table();
				end
				ptc_pkg::OP_NOTE: begin
					if (int'(it.pitch) < ptc_pkg::PITCHES) begin
						if (prev_ok && !it.song_start) begin
							idx = int'(prev_pitch) * ptc_pkg::PITCHES + int'(it.pitch);
							if (pair_hits[idx] != ptc_pkg::COUNT_MAX)
								pair_hits[idx]++;
							if (total != ptc_pkg::TOTAL_MAX)
								total++;
						end
						prev_pitch = it.pitch;
						prev_ok = 1'b1;
					end
				end
				ptc_pkg::OP_REPORT: begin
					limit = (int'(it.top_n) > ptc_pkg::MAX_TOP) ? ptc_pkg::MAX_TOP
						: int'(it.top_n);
					have_held = 1'b0;
					for (int rank = 0; rank < limit; rank++) begin
						best = '0;
						best_idx = 0;
						for (idx = 0; idx < ptc_pkg::PITCHES * ptc_pkg::PITCHES; idx++) begin
							if (pair_hits[idx] > best) begin
								best = pair_hits[idx];
								best_idx = idx;
							end
						end
						if (best == 0)
							break;
						pair_hits[best_idx] = '0;
						if (have_held) begin
							pending_beats.push_back(held);
							beats_predicted++;
						end
						held.from_pitch = ptc_pkg::PITCH_W'(best_idx / ptc_pkg::PITCHES);
						held.to_pitch = ptc_pkg::PITCH_W'(best_idx % ptc_pkg::PITCHES);
						held.hit_count = ptc_pkg::HIT_W'(best);
						held.total_count = total;
						held.found = 1'b1;
						held.last = 1'b0;
						have_held = 1'b1;
					end
					if (!have_held) begin
						held = '0;
						held.total_count = total;
					end
					held.last = 1'b1;
					pending_beats.push_back(held);
					beats_predicted++;
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string field, longint unsigned want,
			longint unsigned seen);
			if (want != seen) begin
				$error("%s: expected %0d, got %0d", field, want, seen);
				errors++;
			end
		endfunction

		function void check_beat(ptc_pkg::result_t seen);
			ptc_pkg::result_t want;
			if (pending_beats.size() == 0) begin
				$error("result beat with no report pending");
				errors++;
				return;
			end
			want = pending_beats.pop_front();
			beats_checked++;
			compare_field("from_pitch", want.from_pitch, seen.from_pitch);
			compare_field("to_pitch", want.to_pitch, seen.to_pitch);
			compare_field("hit_count", want.hit_count, seen.hit_count);
			compare_field("total_count", want.total_count, seen.total_count);
			compare_field("found", want.found, seen.found);
			compare_field("last", want.last, seen.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [63:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	transition_scoreboard sb = new();
	int quiet_cycles = 0;
	bit paced = 1'b1;
	int burst_left = 0;
	bit pressure_done = 1'b0;

	pitch_transition_counter_top_n dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// beat monitor
	always @(posedge clk) begin
		ptc_pkg::item_t it;
		ptc_pkg::result_t res;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				it.op = s_tuser;
				it.pitch = s_tdata[6:0];
				it.song_start = s_tdata[7];
				it.top_n = s_tdata[14:8];
				sb.take_item(it);
			end
			if (m_tvalid && m_tready) begin
				res.from_pitch = m_tdata[6:0];
				res.to_pitch = m_tdata[13:7];
				res.hit_count = m_tdata[29:14];
				res.total_count = m_tdata[61:30];
				res.found = m_tuser;
				res.last = m_tlast;
				sb.check_beat(res);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// receiver: runs of steady ready, patterned stalls and random stalls
	initial begin
		int mode;
		int len;
		bit [15:0] pat;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!pressure_done && sb.beats_checked >= 3) begin
				pressure_done = 1'b1;
				@(negedge clk);
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			len = $urandom_range(4, 64);
			pat = 16'($urandom);
			for (int i = 0; i < len; i++) begin
				@(negedge clk);
				case (mode)
					1: m_tready = pat[i % 16];
					2: m_tready = $urandom_range(0, 1);
					default: m_tready = 1'b1;
				endcase
			end
		end
	end

	task automatic offer_item(input logic [1:0] op, input int pitch, input bit song_start,
		input int top_n);
		if (paced) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) begin
					@(negedge clk);
					s_tvalid = 1'b0;
					repeat ($urandom_range(0, 10)) @(negedge clk);
				end
			end
			burst_left--;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {1'b0, ptc_pkg::TOPN_W'(top_n), song_start, ptc_pkg::PITCH_W'(pitch)};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic offer_random_item();
		int sel;
		int pitch;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			offer_item(ptc_pkg::OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 1),
				$urandom_range(0, 127));
		else if (sel < 6)
			offer_item(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 1),
				$urandom_range(0, 127));
		else if (sel < 15)
			offer_item(ptc_pkg::OP_REPORT, $urandom_range(0, 127), $urandom_range(0, 1),
				($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
		else begin
			pitch = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5)
				: $urandom_range(0, 127);
			offer_item(ptc_pkg::OP_NOTE, pitch, $urandom_range(0, 19) == 0,
				$urandom_range(0, 127));
		end
	endtask

	initial begin
		int n;
		int start_beats;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extreme pitches, song start, unused op
		offer_item(ptc_pkg::OP_REPORT, $urandom_range(0, 127), 1'b1, 5);
		offer_item(ptc_pkg::OP_NOTE, 0, 1'b0, $urandom_range(0, 127));
		offer_item(ptc_pkg::OP_NOTE, 127, 1'b0, 0);
		offer_item(ptc_pkg::OP_NOTE, 127, 1'b0, 127);
		offer_item(ptc_pkg::OP_NOTE, 0, 1'b0, 0);
		offer_item(ptc_pkg::OP_NOTE, 127, 1'b0, 127);
		offer_item(ptc_pkg::OP_NOTE, 85, 1'b1, 0);
		offer_item(ptc_pkg::OP_NOTE, 42, 1'b0, 85);
		offer_item(OP_UNUSED, 127, 1'b1, 127);
		offer_item(ptc_pkg::OP_REPORT, 127, 1'b1, 0);
		offer_item(ptc_pkg::OP_REPORT, 0, 1'b0, 127);
		offer_item(ptc_pkg::OP_NOTE, 42, 1'b0, 0);
		offer_item(ptc_pkg::OP_NOTE, 1, 1'b0, 0);
		// clear keeps the previous note
		offer_item(ptc_pkg::OP_CLEAR, 127, 1'b1, 127);
		offer_item(ptc_pkg::OP_NOTE, 2, 1'b0, 0);
		offer_item(ptc_pkg::OP_NOTE, 3, 1'b0, 0);
		offer_item(ptc_pkg::OP_NOTE, 2, 1'b0, 0);
		offer_item(ptc_pkg::OP_REPORT, 0, 1'b0, 64);
		offer_item(ptc_pkg::OP_REPORT, 0, 1'b0, 1);

		// one pair counter hit repeatedly, back to back
		paced = 1'b0;
		offer_item(ptc_pkg::OP_CLEAR, 0, 1'b0, 0);
		offer_item(ptc_pkg::OP_NOTE, 100, 1'b1, 0);
		repeat (RUN_REPEATS) offer_item(ptc_pkg::OP_NOTE, 100, 1'b0, 0);
		offer_item(ptc_pkg::OP_REPORT, 0, 1'b0, 2);
		paced = 1'b1;

		n = 0;
		start_beats = sb.beats_predicted;
		while (n < RANDOM_ITEMS || sb.beats_predicted - start_beats < RANDOM_BEATS) begin
			offer_random_item();
			n++;
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		while (sb.pending_beats.size() != 0)
			@(posedge clk);
		repeat (2 * SCAN_CYCLES) @(posedge clk);

		$display("items: %0d notes, %0d reports, %0d clears, %0d unused ops",
			sb.op_seen[ptc_pkg::OP_NOTE], sb.op_seen[ptc_pkg::OP_REPORT],
			sb.op_seen[ptc_pkg::OP_CLEAR], sb.op_seen[OP_UNUSED]);
		$display("%0d report beats checked, with ties, empty reports and a long output stall",
			sb.beats_checked);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
